>>> rtl/lfscp_pkg.sv
`default_nettype none

package lfscp_pkg;

  // Capture buffer size in bytes
  localparam int unsigned BufferBytes = 65536;

  // Field widths
  localparam int unsigned SampleW   = 8;
  localparam int unsigned SumW      = 11;
  localparam int unsigned DecW      = 4;
  localparam int unsigned CapBytesW = 17;
  localparam int unsigned PosW      = 20;

  // Item actions
  localparam logic [1:0] ActStart  = 2'd0;
  localparam logic [1:0] ActSample = 2'd1;
  localparam logic [1:0] ActStop   = 2'd2;

  // End status codes
  localparam logic [2:0] StRunning   = 3'd0;
  localparam logic [2:0] StFull      = 3'd1;
  localparam logic [2:0] StCancelled = 3'd2;
  localparam logic [2:0] StStopped   = 3'd3;
  localparam logic [2:0] StBudget    = 3'd4;

  // Config register indexes
  localparam logic [2:0] CfgDecimation   = 3'd0;
  localparam logic [2:0] CfgBitsPerSmp   = 3'd1;
  localparam logic [2:0] CfgAveraging    = 3'd2;
  localparam logic [2:0] CfgThreshold    = 3'd3;
  localparam logic [2:0] CfgSkipCount    = 3'd4;
  localparam logic [2:0] CfgCancelLimit  = 3'd5;
  localparam logic [2:0] CfgCaptureBytes = 3'd6;

  // One output beat
  typedef struct packed {
    logic [15:0] byte_index;
    logic [7:0]  byte_value;
    logic [19:0] bit_count;
    logic [2:0]  status;
    logic        last;
  } result_t;

  // Clamp a 4-bit setting into 1..8
  function automatic logic [DecW-1:0] clamp_1_8(input logic [DecW-1:0] v);
    logic [DecW-1:0] r;
    r = v;
    if (v == '0) r = 4'd1;
    else if (v > 4'd8) r = 4'd8;
    return r;
  endfunction

  // Mask with the top n bits set, n in 1..8
  function automatic logic [7:0] top_mask(input logic [DecW-1:0] n);
    logic [7:0] m;
    m = ~(8'hFF >> n);
    return m;
  endfunction

endpackage

`default_nettype wire

>>> rtl/lf_sample_capture_packer.sv
`default_nettype none

// Low-frequency ADC capture and bit packer. A start beat arms a capture and
// returns no result. Sample beats pass the trigger band, skip and 1-in-N
// decimation (optionally averaged), and the top bits of each kept value are
// packed MSB-first; every completed byte is returned as one result beat, and
// the capture's final beat carries last=1 with the end status. The block takes
// one beat at a time. A start or a dropped sample passes the decide state only,
// a stored sample passes decide, pack and room check, and an averaged group end
// first waits in the iterative divider; each result beat then holds the block
// until it is taken. An ending passes the end state. Configuration is written
// through cfg_we_i/cfg_idx_i/cfg_data_i while idle, by the user; the block does not enforce it.
module lf_sample_capture_packer (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Config write port
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [19:0] cfg_data_i,
  // Input channel
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  action_i,
  input  wire logic [7:0]  sample_i,
  // Output channel
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [15:0]      byte_index_o,
  output logic [7:0]       byte_value_o,
  output logic [19:0]      bit_count_o,
  output logic [2:0]       status_o,
  output logic             last_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECIDE = 3'd1;
  localparam logic [2:0] S_DIV    = 3'd2;
  localparam logic [2:0] S_PACK   = 3'd3;
  localparam logic [2:0] S_CHK    = 3'd4;
  localparam logic [2:0] S_FIN    = 3'd5;
  localparam logic [2:0] S_OUT    = 3'd6;

  localparam int unsigned PosW = lfscp_pkg::PosW;
  localparam logic [lfscp_pkg::CapBytesW-1:0] BufBytes =
    lfscp_pkg::CapBytesW'(lfscp_pkg::BufferBytes);

  // Config registers
  logic [3:0]  dec_q, bps_q;
  logic        avg_q;
  logic [7:0]  thr_q;
  logic [19:0] skip_cfg_q;
  logic [15:0] cancel_lim_q;
  logic [16:0] cap_bytes_q;

  // Sequencer and capture state
  logic [2:0]            state_q, state_d;
  logic [1:0]            act_q, act_d;
  logic [7:0]            smp_q, smp_d;
  logic                  capturing_q, capturing_d;
  logic                  triggered_q, triggered_d;
  logic [19:0]           skip_left_q, skip_left_d;
  logic [15:0]           cancel_seen_q, cancel_seen_d;
  logic [2:0]            group_count_q, group_count_d;
  logic [10:0]           group_sum_q, group_sum_d;
  logic [16:0]           budget_q, budget_d;
  logic [7:0]            pack_byte_q, pack_byte_d;
  logic [PosW-1:0]       pos_q, pos_d;
  logic [7:0]            v_q, v_d;
  logic [2:0]            fin_st_q, fin_st_d;
  logic                  byte_done_q, byte_done_d;
  lfscp_pkg::result_t    res_q [2];
  lfscp_pkg::result_t    res_d [2];
  logic [1:0]            res_cnt_q, res_cnt_d;
  logic                  rd_q, rd_d;

  // Effective settings and shared compares
  logic [16:0]   eff_bytes;
  logic [19:0]   room;
  logic [3:0]    bps, dec;
  logic          full;
  logic          inband;
  logic [15:0]   cancel_next;
  logic [10:0]   sum_next;
  logic [3:0]    gc_next;

  // Packing datapath
  logic [2:0]    bitp;
  logic [7:0]    vm;
  logic [15:0]   merged;
  logic          completes;
  logic [PosW-1:0] boundary;

  // Divider link
  logic          div_start;
  logic          div_done;
  logic [10:0]   div_quo;

  assign eff_bytes = (cap_bytes_q == '0 || cap_bytes_q > BufBytes) ? BufBytes : cap_bytes_q;
  assign room      = {eff_bytes, 3'b000};
  assign bps       = lfscp_pkg::clamp_1_8(bps_q);
  assign dec       = lfscp_pkg::clamp_1_8(dec_q);
  assign full      = ({1'b0, pos_q} + {17'd0, bps}) > {1'b0, room};

  assign inband = (thr_q != '0) &&
                  ({1'b0, smp_q} < ({1'b0, thr_q} + 9'd128)) &&
                  (({1'b0, smp_q} + {1'b0, thr_q}) > 9'd128);
  assign cancel_next = cancel_seen_q + 16'd1;
  assign sum_next    = avg_q ? (group_sum_q + {3'd0, smp_q}) : group_sum_q;
  assign gc_next     = {1'b0, group_count_q} + 4'd1;

  // Merge top bits of the kept value at the current bit position
  assign bitp      = pos_q[2:0];
  assign vm        = v_q & lfscp_pkg::top_mask(bps);
  assign merged    = {pack_byte_q, 8'h00} | ({vm, 8'h00} >> bitp);
  assign completes = ({1'b0, bitp} + bps) >= 4'd8;
  assign boundary  = {pos_q[PosW-1:3] + 17'd1, 3'b000};

  lfscp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_next),
    .divisor_i  (dec),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // Sequencer
  always_comb begin
    state_d       = state_q;
    act_d         = act_q;
    smp_d         = smp_q;
    capturing_d   = capturing_q;
    triggered_d   = triggered_q;
    skip_left_d   = skip_left_q;
    cancel_seen_d = cancel_seen_q;
    group_count_d = group_count_q;
    group_sum_d   = group_sum_q;
    budget_d      = budget_q;
    pack_byte_d   = pack_byte_q;
    pos_d         = pos_q;
    v_d           = v_q;
    fin_st_d      = fin_st_q;
    byte_done_d   = byte_done_q;
    res_d         = res_q;
    res_cnt_d     = res_cnt_q;
    rd_d          = rd_q;
    div_start     = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          act_d   = action_i;
          smp_d   = sample_i;
          state_d = S_DECIDE;
        end
      end

      S_DECIDE: begin
        res_cnt_d   = '0;
        rd_d        = 1'b0;
        byte_done_d = 1'b0;
        state_d     = S_IDLE;
        case (act_q)
          lfscp_pkg::ActStart: begin
            capturing_d   = 1'b1;
            triggered_d   = 1'b0;
            skip_left_d   = skip_cfg_q;
            cancel_seen_d = '0;
            group_count_d = '0;
            group_sum_d   = '0;
            budget_d      = eff_bytes;
            pack_byte_d   = '0;
            pos_d         = '0;
          end
          lfscp_pkg::ActStop: begin
            if (capturing_q) begin
              fin_st_d = lfscp_pkg::StStopped;
              state_d  = S_FIN;
            end
          end
          lfscp_pkg::ActSample: begin
            if (capturing_q) begin
              if (!triggered_q && inband) begin
                // Pre-trigger in-band sample: may count toward cancel
                if (cancel_lim_q != '0) begin
                  cancel_seen_d = cancel_next;
                  if (cancel_next >= cancel_lim_q) begin
                    fin_st_d = lfscp_pkg::StCancelled;
                    state_d  = S_FIN;
                  end
                end
              end else begin
                triggered_d = 1'b1;
                if (skip_left_q != '0) begin
                  skip_left_d = skip_left_q - 20'd1;
                end else if (budget_q == '0) begin
                  fin_st_d = lfscp_pkg::StBudget;
                  state_d  = S_FIN;
                end else begin
                  budget_d    = budget_q - 17'd1;
                  group_sum_d = sum_next;
                  if (dec > 4'd1 && gc_next < dec) begin
                    group_count_d = gc_next[2:0];
                  end else begin
                    if (dec > 4'd1) group_count_d = '0;
                    group_sum_d = '0;
                    if (dec > 4'd1 && avg_q) begin
                      div_start = 1'b1;
                      state_d   = S_DIV;
                    end else begin
                      v_d     = smp_q;
                      state_d = S_PACK;
                    end
                  end
                end
              end
            end
          end
          default: ;
        endcase
      end

      // Wait for the group mean, saturate to 8 bits
      S_DIV: begin
        if (div_done) begin
          v_d     = (div_quo[10:8] != '0) ? 8'hFF : div_quo[7:0];
          state_d = S_PACK;
        end
      end

      S_PACK: begin
        if (full) begin
          fin_st_d = lfscp_pkg::StFull;
          state_d  = S_FIN;
        end else begin
          pos_d   = pos_q + {16'd0, bps};
          state_d = S_CHK;
          if (completes) begin
            pack_byte_d           = merged[7:0];
            res_d[0].byte_index   = pos_q[18:3];
            res_d[0].byte_value   = merged[15:8];
            res_d[0].bit_count    = boundary;
            res_d[0].status       = lfscp_pkg::StRunning;
            res_d[0].last         = 1'b0;
            res_cnt_d             = 2'd1;
            byte_done_d           = 1'b1;
          end else begin
            pack_byte_d = merged[15:8];
          end
        end
      end

      // Room check after a store
      S_CHK: begin
        if (full) begin
          fin_st_d = lfscp_pkg::StFull;
          state_d  = S_FIN;
        end else if (res_cnt_q != '0) begin
          state_d = S_OUT;
        end else begin
          state_d = S_IDLE;
        end
      end

      // End of capture: flush partial byte or mark the final beat
      S_FIN: begin
        capturing_d = 1'b0;
        state_d     = S_OUT;
        if (bitp != '0) begin
          res_d[res_cnt_q[0]].byte_index = pos_q[18:3];
          res_d[res_cnt_q[0]].byte_value = pack_byte_q;
          res_d[res_cnt_q[0]].bit_count  = pos_q;
          res_d[res_cnt_q[0]].status     = fin_st_q;
          res_d[res_cnt_q[0]].last       = 1'b1;
          res_cnt_d   = res_cnt_q + 2'd1;
          pack_byte_d = '0;
        end else if (byte_done_q) begin
          res_d[0].status = fin_st_q;
          res_d[0].last   = 1'b1;
        end else begin
          res_d[res_cnt_q[0]].byte_index = pos_q[18:3];
          res_d[res_cnt_q[0]].byte_value = '0;
          res_d[res_cnt_q[0]].bit_count  = pos_q;
          res_d[res_cnt_q[0]].status     = fin_st_q;
          res_d[res_cnt_q[0]].last       = 1'b1;
          res_cnt_d = res_cnt_q + 2'd1;
        end
      end

      // Hand out the queued result beats in order
      S_OUT: begin
        if (out_ready_i) begin
          if (({1'b0, rd_q} + 2'd1) == res_cnt_q) begin
            state_d = S_IDLE;
          end else begin
            rd_d = 1'b1;
          end
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dec_q        <= 4'd1;
      bps_q        <= 4'd8;
      avg_q        <= 1'b1;
      thr_q        <= '0;
      skip_cfg_q   <= '0;
      cancel_lim_q <= '0;
      cap_bytes_q  <= 17'h10000;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lfscp_pkg::CfgDecimation:   dec_q        <= cfg_data_i[3:0];
        lfscp_pkg::CfgBitsPerSmp:   bps_q        <= cfg_data_i[3:0];
        lfscp_pkg::CfgAveraging:    avg_q        <= cfg_data_i[0];
        lfscp_pkg::CfgThreshold:    thr_q        <= cfg_data_i[7:0];
        lfscp_pkg::CfgSkipCount:    skip_cfg_q   <= cfg_data_i;
        lfscp_pkg::CfgCancelLimit:  cancel_lim_q <= cfg_data_i[15:0];
        lfscp_pkg::CfgCaptureBytes: cap_bytes_q  <= cfg_data_i[16:0];
        default: ;
      endcase
    end
  end

  // Control and capture state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      capturing_q   <= 1'b0;
      triggered_q   <= 1'b0;
      skip_left_q   <= '0;
      cancel_seen_q <= '0;
      group_count_q <= '0;
      group_sum_q   <= '0;
      budget_q      <= '0;
      pack_byte_q   <= '0;
      pos_q         <= '0;
      fin_st_q      <= lfscp_pkg::StRunning;
      byte_done_q   <= 1'b0;
      res_cnt_q     <= '0;
      rd_q          <= 1'b0;
    end else begin
      state_q       <= state_d;
      capturing_q   <= capturing_d;
      triggered_q   <= triggered_d;
      skip_left_q   <= skip_left_d;
      cancel_seen_q <= cancel_seen_d;
      group_count_q <= group_count_d;
      group_sum_q   <= group_sum_d;
      budget_q      <= budget_d;
      pack_byte_q   <= pack_byte_d;
      pos_q         <= pos_d;
      fin_st_q      <= fin_st_d;
      byte_done_q   <= byte_done_d;
      res_cnt_q     <= res_cnt_d;
      rd_q          <= rd_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    act_q <= act_d;
    smp_q <= smp_d;
    v_q   <= v_d;
    res_q <= res_d;
  end

  assign in_ready_o   = (state_q == S_IDLE);
  assign out_valid_o  = (state_q == S_OUT);
  assign byte_index_o = res_q[rd_q].byte_index;
  assign byte_value_o = res_q[rd_q].byte_value;
  assign bit_count_o  = res_q[rd_q].bit_count;
  assign status_o     = res_q[rd_q].status;
  assign last_o       = res_q[rd_q].last;

endmodule

`default_nettype wire

>>> rtl/lfscp_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle over the group sum width.
module lfscp_div (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start_i,
  input  wire logic [lfscp_pkg::SumW-1:0]     dividend_i,
  input  wire logic [lfscp_pkg::DecW-1:0]     divisor_i,
  output logic                                done_o,
  output logic [lfscp_pkg::SumW-1:0]          quotient_o
);

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [3:0]                    cnt_q, cnt_d;
  logic [lfscp_pkg::DecW-1:0]    rem_q, rem_d;
  logic [lfscp_pkg::DecW-1:0]    div_q, div_d;
  logic [lfscp_pkg::SumW-1:0]    quo_q, quo_d;
  logic [lfscp_pkg::DecW:0]      trial;
  logic                          ge;

  // Shift in the next dividend bit and compare
  assign trial = {rem_q, quo_q[lfscp_pkg::SumW-1]};
  assign ge    = trial >= {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    div_d  = div_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      div_d  = divisor_i;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      rem_d = ge ? 4'(trial - {1'b0, div_q}) : trial[lfscp_pkg::DecW-1:0];
      quo_d = {quo_q[lfscp_pkg::SumW-2:0], ge};
      cnt_d = cnt_q + 4'd1;
      if (cnt_q == 4'(lfscp_pkg::SumW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    div_q <= div_d;
    quo_q <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

>>> bench/tb_lf_sample_capture_packer.sv
`default_nettype none

module tb_lf_sample_capture_packer;
  timeunit 1ns;
  timeprecision 1ps;

  import lfscp_pkg::*;

  // Action code the block must ignore
  localparam logic [1:0] ActIgnored = 2'd3;
  // Cycles to let an item with no result work its way out before a register write
  localparam int unsigned SettleCycles = 40;
  localparam int unsigned ItemsPerPhase = 400;
  localparam int unsigned PrintLimit = 40;
  localparam int unsigned NumRows = 51;

  localparam result_t NoBeat = '0;

  // One row of the directed plan: a register write or an input beat
  typedef struct packed {
    logic        is_cfg;
    logic [2:0]  reg_idx;
    logic [19:0] reg_data;
    logic [1:0]  act;
    logic [7:0]  smp;
    logic        typed;
    result_t     want;
  } plan_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = CfgDecimation;
  logic [19:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  action_i = ActStart;
  logic [7:0]  sample_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [15:0] byte_index_o;
  logic [7:0]  byte_value_o;
  logic [19:0] bit_count_o;
  logic [2:0]  status_o;
  logic        last_o;

  int unsigned send_idle_pct = 7;
  int unsigned recv_stall_pct = 88;
  int unsigned err_count = 0;
  int unsigned live_items = 0;

  // Shadow of the configuration registers
  logic [3:0]  sh_dec = 4'd1;
  logic [3:0]  sh_bps = 4'd8;
  logic        sh_avg = 1'b1;
  logic [7:0]  sh_thr = '0;
  logic [19:0] sh_skip = '0;
  logic [15:0] sh_cancel = '0;
  logic [16:0] sh_cap = 17'd65536;

  // Shadow of the capture state
  logic        cap_on = 1'b0;
  logic        trig_seen = 1'b0;
  logic [19:0] skip_left = '0;
  logic [15:0] cancel_seen = '0;
  logic [3:0]  grp_count = '0;
  logic [10:0] grp_sum = '0;
  logic [16:0] budget_left = '0;
  logic [7:0]  pack_acc = '0;
  logic [19:0] pack_pos = '0;
  logic        byte_closed = 1'b0;

  result_t step_bytes[$];
  result_t pending_bytes[$];

  // Directed plan: walk the endings, the extremes and the register corners
  plan_row_t plan [NumRows] = '{
    '{1'b0, CfgDecimation, 20'd0, ActStart, 8'h00, 1'b0, NoBeat},
    '{1'b0, CfgDecimation, 20'd0, ActSample, 8'h00, 1'b1,
      '{16'd0, 8'h00, 20'd8, StRunning, 1'b0}},
    '{1'b0, CfgDecimation, 20'd0, ActSample, 8'hFF, 1'b1,
      '{16'd1, 8'hFF, 20'd16, StRunning, 1'b0}},
    '{1'b0, CfgDecimation, 20'd0, ActStop, 8'h00, 1'b1,
      '{16'd2, 8'h00, 20'd16, StStopped, 1'b1}},
    '{1'b0, CfgDecimation, 20'd0, ActIgnored, 8'hAA, 1'b0, NoBeat},
    // one-byte buffer fills on the first sample
    '{1'b1, CfgCaptureBytes, 20'd1, ActStart, 8'h00, 1'b0, NoBeat},
    '{1'b0, CfgDecimation, 20'd0, ActStart, 8'h00, 1'b0, NoBeat},
    '{1'b0, CfgDecimation, 20'd0, ActSample, 8'hA5, 1'b1,
      '{16'd0, 8'hA5, 20'd8, StFull, 1'b1}},
    // out-of-range decimation and width, budget of one sample
    '{1'b1, CfgDecimation, 20'd15, ActStart, 8'h00, 1'b0, NoBeat},
    '{1'b1, CfgBitsPerSmp, 20'd0, ActStart, 8'h00, 1'b0, NoBeat},
    '{1'b0, CfgDecimation, 20'd0, ActStart, 8'h00, 1'b0, NoBeat},
    '{1'b0, CfgDecimation, 20'd0, ActSample, 8'h80, 1'b0, NoBeat},
    '{1'b0, CfgDecimation, 20'd0, ActSample, 8'h80, 1'b1,
      '{16'd0, 8'h00, 20'd0, StBudget, 1'b1}},
    // in-band samples cancel before the trigger
    '{1'b1, CfgThreshold, 20'd10, ActStart, 8'h00, 1'b0, NoBeat},
    '{1'b1, CfgCancelLimit, 20'd2, ActStart, 8'h00, 1'b0, NoBeat},
    '{1'b0, CfgDecimation, 20'd0, ActStart, 8'h00, 1'b0, NoBeat},
    '{1'b0, CfgDecimation, 20'd0, ActSample, 8'h80, 1'b0, NoBeat},
    '{1'b0, CfgDecimation, 20'd0, ActSample, 8'h87, 1'b1,
      '{16'd0, 8'h00, 20'd0, StCancelled, 1'b1}},
    // trigger, skip, averaged pair, then plain decimation mid-capture
    '{1'b1, CfgCancelLimit, 20'd0, ActStart, 8'h00, 1'b0, NoBeat},
    '{1'b1, CfgCaptureBytes, 20'd0, ActStart, 8'h00, 1'b0, NoBeat},
    '{1'b1, CfgDecimation, 20'd2, ActStart, 8'h00, 1'b0, NoBeat},
    '{1'b1, CfgBitsPerSmp, 20'd8, ActStart, 8'h00, 1'b0, NoBeat},
    '{1'b1, CfgSkipCount, 20'd1, ActStart, 8'h00, 1'b0, NoBeat},
    '{1'b0, CfgDecimation, 20'd0, ActStart, 8'h00, 1'b0, NoBeat},
    '{1'b0, CfgDecimation, 20'd0, ActSample, 8'h82, 1'b0, NoBeat},
    '{1'b0, CfgDecimation, 20'd0, ActSample, 8'hC8, 1'b0, NoBeat},
    '{1'b0, CfgDecimation, 20'd0, ActSample, 8'hC0, 1'b0, NoBeat},
    '{1'b0, CfgDecimation, 20'd0, ActSample, 8'hFF, 1'b0, NoBeat},
    '{1'b1, CfgAveraging, 20'd0, ActStart, 8'h00, 1'b0, NoBeat},
    '{1'b0, CfgDecimation, 20'd0, ActSample, 8'h11, 1'b0, NoBeat},
    '{1'b0, CfgDecimation, 20'd0, ActSample, 8'h40, 1'b0, NoBeat},
    '{1'b0, CfgDecimation, 20'd0, ActStop, 8'h00, 1'b0, NoBeat},
    // buffer shrunk mid-capture: the next sample no longer fits
    '{1'b1, CfgDecimation, 20'd1, ActStart, 8'h00, 1'b0, NoBeat},
    '{1'b1, CfgBitsPerSmp, 20'd3, ActStart, 8'h00, 1'b0, NoBeat},
    '{1'b1, CfgSkipCount, 20'd0, ActStart, 8'h00, 1'b0, NoBeat},
    '{1'b1, CfgThreshold, 20'd0, ActStart, 8'h00, 1'b0, NoBeat},
    '{1'b1, CfgCaptureBytes, 20'd3, ActStart, 8'h00, 1'b0, NoBeat},
    '{1'b0, CfgDecimation, 20'd0, ActStart, 8'h00, 1'b0, NoBeat},
    '{1'b0, CfgDecimation, 20'd0, ActSample, 8'hE0, 1'b0, NoBeat},
    '{1'b0, CfgDecimation, 20'd0, ActSample, 8'h40, 1'b0, NoBeat},
    '{1'b1, CfgCaptureBytes, 20'd1, ActStart, 8'h00, 1'b0, NoBeat},
    '{1'b0, CfgDecimation, 20'd0, ActSample, 8'hFF, 1'b1,
      '{16'd0, 8'hE8, 20'd6, StFull, 1'b1}},
    // register extremes, then an empty capture
    '{1'b1, CfgThreshold, 20'd255, ActStart, 8'h00, 1'b0, NoBeat},
    '{1'b1, CfgCancelLimit, 20'hFFFF, ActStart, 8'h00, 1'b0, NoBeat},
    '{1'b1, CfgSkipCount, 20'hFFFFF, ActStart, 8'h00, 1'b0, NoBeat},
    '{1'b1, CfgCaptureBytes, 20'hFFFFF, ActStart, 8'h00, 1'b0, NoBeat},
    '{1'b1, CfgBitsPerSmp, 20'd15, ActStart, 8'h00, 1'b0, NoBeat},
    '{1'b1, CfgDecimation, 20'd0, ActStart, 8'h00, 1'b0, NoBeat},
    '{1'b1, CfgAveraging, 20'd1, ActStart, 8'h00, 1'b0, NoBeat},
    '{1'b0, CfgDecimation, 20'd0, ActStart, 8'h00, 1'b0, NoBeat},
    '{1'b0, CfgDecimation, 20'd0, ActStop, 8'h00, 1'b1,
      '{16'd0, 8'h00, 20'd0, StStopped, 1'b1}}
  };

  lf_sample_capture_packer DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .action_i     (action_i),
    .sample_i     (sample_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .byte_index_o (byte_index_o),
    .byte_value_o (byte_value_o),
    .bit_count_o  (bit_count_o),
    .status_o     (status_o),
    .last_o       (last_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Capture predictor
  // ---------------------------------------------------------------------------

  function automatic int unsigned limit_1_to_8(input logic [3:0] v);
    if (v == 4'd0) return 1;
    if (v > 4'd8) return 8;
    return v;
  endfunction

  function automatic int unsigned buffer_bytes();
    if (sh_cap == '0 || sh_cap > BufferBytes) return BufferBytes;
    return sh_cap;
  endfunction

  function automatic void push_byte(input int unsigned idx, input logic [7:0] val,
                                    input logic [2:0] st, input logic lst);
    result_t r;
    r.byte_index = 16'(idx);
    r.byte_value = val;
    r.bit_count  = pack_pos;
    r.status     = st;
    r.last       = lst;
    step_bytes.push_back(r);
  endfunction

  // Close the capture: flush a partial byte, else tag this beat's byte, else
  // return an empty marker beat
  function automatic void end_capture(input logic [2:0] st);
    result_t r;
    cap_on = 1'b0;
    if (pack_pos[2:0] != 3'd0) begin
      push_byte(pack_pos >> 3, pack_acc, st, 1'b1);
      pack_acc = '0;
    end else if (byte_closed && step_bytes.size() > 0) begin
      r = step_bytes.pop_back();
      r.status = st;
      r.last   = 1'b1;
      step_bytes.push_back(r);
    end else begin
      push_byte(pack_pos >> 3, 8'h00, st, 1'b1);
    end
  endfunction

  // Pack the top bits of one kept value, MSB first
  function automatic void pack_value(input logic [7:0] v);
    int unsigned n;
    int unsigned i;
    n = limit_1_to_8(sh_bps);
    for (i = 0; i < n; i++) begin
      if (v[7 - i]) pack_acc[3'd7 - pack_pos[2:0]] = 1'b1;
      pack_pos = pack_pos + 20'd1;
      if (pack_pos[2:0] == 3'd0) begin
        push_byte((pack_pos >> 3) - 1, pack_acc, StRunning, 1'b0);
        pack_acc = '0;
        byte_closed = 1'b1;
      end
    end
  endfunction

  function automatic void model_sample(input logic [7:0] s);
    int unsigned dec, room, v, t, nc;
    dec  = limit_1_to_8(sh_dec);
    room = buffer_bytes() * 8;
    v    = s;
    // trigger band and cancel count
    if (!trig_seen) begin
      t = sh_thr;
      if (t > 0 && s < t + 128 && s + t > 128) begin
        if (sh_cancel != '0) begin
          cancel_seen = cancel_seen + 16'd1;
          if (cancel_seen >= sh_cancel) end_capture(StCancelled);
        end
        return;
      end
      trig_seen = 1'b1;
    end
    if (skip_left != '0) begin
      skip_left = skip_left - 20'd1;
      return;
    end
    if (budget_left == '0) begin
      end_capture(StBudget);
      return;
    end
    budget_left = budget_left - 17'd1;
    // decimation, with optional group mean
    if (sh_avg) grp_sum = grp_sum + 11'(s);
    if (dec > 1) begin
      nc = grp_count + 1;
      if (nc < dec) begin
        grp_count = 4'(nc);
        return;
      end
      grp_count = '0;
      if (sh_avg) begin
        v = grp_sum / dec;
        if (v > 255) v = 255;
      end
    end
    grp_sum = '0;
    if (pack_pos + limit_1_to_8(sh_bps) > room) begin
      end_capture(StFull);
      return;
    end
    pack_value(v[7:0]);
    if (pack_pos + limit_1_to_8(sh_bps) > room) end_capture(StFull);
  endfunction

  function automatic void packer_step(input logic [1:0] act, input logic [7:0] s);
    step_bytes.delete();
    byte_closed = 1'b0;
    case (act)
      ActStart: begin
        cap_on      = 1'b1;
        trig_seen   = 1'b0;
        skip_left   = sh_skip;
        cancel_seen = '0;
        grp_count   = '0;
        grp_sum     = '0;
        budget_left = 17'(buffer_bytes());
        pack_acc    = '0;
        pack_pos    = '0;
      end
      ActSample: begin
        if (cap_on) model_sample(s);
      end
      ActStop: begin
        if (cap_on) end_capture(StStopped);
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (err_count < PrintLimit) begin
      $display("%0t: MISMATCH %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    end
    err_count++;
  endtask

  task automatic check_beat();
    result_t want;
    if (pending_bytes.size() == 0) begin
      report_mismatch("unexpected result beat, byte_index", byte_index_o, 0);
    end else begin
      want = pending_bytes.pop_front();
      if (byte_index_o !== want.byte_index)
        report_mismatch("byte_index", byte_index_o, want.byte_index);
      if (byte_value_o !== want.byte_value)
        report_mismatch("byte_value", byte_value_o, want.byte_value);
      if (bit_count_o !== want.bit_count)
        report_mismatch("bit_count", bit_count_o, want.bit_count);
      if (status_o !== want.status)
        report_mismatch("status", status_o, want.status);
      if (last_o !== want.last)
        report_mismatch("last", last_o, want.last);
    end
  endtask

  // Output side: random stalls, check each taken beat
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) check_beat();
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Present one beat; expectations are queued up front since beats are taken in order
  task automatic send_item(input logic [1:0] act, input logic [7:0] smp,
                           input logic typed, input result_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    live_items++;
    packer_step(act, smp);
    if (typed) pending_bytes.push_back(want);
    else foreach (step_bytes[k]) pending_bytes.push_back(step_bytes[k]);
    in_valid_i <= 1'b1;
    action_i   <= act;
    sample_i   <= smp;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Hold the input off until every expected beat is back and the block settles
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_bytes.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [19:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      CfgDecimation:   sh_dec = data[3:0];
      CfgBitsPerSmp:   sh_bps = data[3:0];
      CfgAveraging:    sh_avg = data[0];
      CfgThreshold:    sh_thr = data[7:0];
      CfgSkipCount:    sh_skip = data;
      CfgCancelLimit:  sh_cancel = data[15:0];
      CfgCaptureBytes: sh_cap = data[16:0];
      default: ;
    endcase
  endtask

  // Mostly small buffers and short skips so captures end often
  task automatic randomize_setup();
    int unsigned r;
    logic [19:0] val;
    r = $urandom_range(3);
    val = (r == 0) ? 20'($urandom_range(15)) : 20'($urandom_range(3, 1));
    write_reg(CfgDecimation, {16'($urandom), val[3:0]});
    write_reg(CfgBitsPerSmp, {16'($urandom), 4'($urandom_range(15))});
    write_reg(CfgAveraging, 20'($urandom));
    r = $urandom_range(9);
    val = (r < 4) ? 20'd0 : (r < 8) ? 20'($urandom_range(20, 1)) : 20'($urandom_range(255));
    write_reg(CfgThreshold, {12'($urandom), val[7:0]});
    r = $urandom_range(19);
    val = (r < 12) ? 20'd0 : (r < 19) ? 20'($urandom_range(5, 1)) : 20'($urandom);
    write_reg(CfgSkipCount, val);
    r = $urandom_range(9);
    val = (r < 6) ? 20'd0 : (r < 9) ? 20'($urandom_range(6, 1)) : 20'($urandom);
    write_reg(CfgCancelLimit, {4'($urandom), val[15:0]});
    r = $urandom_range(9);
    if (r < 5) val = 20'($urandom_range(4, 1));
    else if (r < 8) val = 20'($urandom_range(40, 5));
    else if (r < 9) val = 20'd0;
    else val = 20'($urandom);
    write_reg(CfgCaptureBytes, val);
  endtask

  // Samples often fall near the trigger band so both sides of it are seen
  function automatic logic [7:0] pick_sample();
    int t, lo, hi;
    t = sh_thr;
    if (t != 0 && $urandom_range(1) == 1) begin
      lo = 128 - t;
      hi = 128 + t;
      if (lo < 0) lo = 0;
      if (hi > 255) hi = 255;
      return 8'($urandom_range(hi, lo));
    end
    return 8'($urandom_range(255));
  endfunction

  // One capture (now and then only stray beats): start, a run of samples with a little noise, maybe a stop
  task automatic run_capture();
    int unsigned n_samp, k, r;
    logic [1:0] act;
    if ($urandom_range(9) == 0) begin
      // stray beats, possibly a start left without an end
      repeat ($urandom_range(6, 1)) send_item(2'($urandom_range(3)), 8'($urandom), 1'b0, NoBeat);
      return;
    end
    send_item(ActStart, 8'($urandom), 1'b0, NoBeat);
    n_samp = $urandom_range(40, 2);
    for (k = 0; k < n_samp; k++) begin
      r = $urandom_range(99);
      if (r < 3) act = ActIgnored;
      else if (r < 5) act = ActStart;
      else act = ActSample;
      if ($urandom_range(29) == 0) wait_idle();
      send_item(act, pick_sample(), 1'b0, NoBeat);
    end
    if ($urandom_range(1) == 1) send_item(ActStop, 8'($urandom), 1'b0, NoBeat);
  endtask

  initial begin
    logic busy;
    int unsigned phase, phase_base;
    busy = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed plan
    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        if (busy) wait_idle();
        busy = 1'b0;
        write_reg(plan[i].reg_idx, plan[i].reg_data);
      end else begin
        send_item(plan[i].act, plan[i].smp, plan[i].typed, plan[i].want);
        busy = 1'b1;
      end
    end

    // random captures under three idling profiles
    for (phase = 0; phase < 3; phase++) begin
      send_idle_pct  = (phase == 0) ? 7 : (phase == 1) ? 88 : 0;
      recv_stall_pct = (phase == 0) ? 88 : (phase == 1) ? 7 : 0;
      phase_base = live_items;
      while (live_items < phase_base + ItemsPerPhase) begin
        wait_idle();
        randomize_setup();
        run_capture();
      end
    end

    wait_idle();
    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire
